FILE: src/assert_macros.svh
// Assertion helpers used by the back stage RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define NPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante held.
`define NPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/nps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nps_pkg;

   localparam int RADIUS_W = 49;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 49'd65536000000;
   localparam int INDEX_W = 12;

   localparam int MAX_POINTS_DEFAULT = 4096;
   localparam int COORD_W_DEFAULT = 24;
   localparam int QUEUE_DEPTH = 2;

   // Per-item control between the front and the back
   typedef struct packed {
      logic start;    // item opens a new search
      logic last;     // item closes the search and emits a result
      logic compare;  // item lies within the point limit
   } nps_flags_type;

   localparam int FLAGS_W = $bits(nps_flags_type);

endpackage
`default_nettype wire

FILE: src/nps_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module nps_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = nps_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  empty
);
   import nps_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: src/nps_front.sv
`timescale 1ns / 1ps
`default_nettype none
module nps_front #(
   parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEFAULT,
   parameter int COORD_W    = nps_pkg::COORD_W_DEFAULT,
   parameter int MID_W      = nps_pkg::FLAGS_W + 4 * COORD_W + 2 + $clog2(MAX_POINTS)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [COORD_W-1:0]  query_x,
   input  wire logic [COORD_W-1:0]  query_y,
   input  wire logic [COORD_W-1:0]  path_x,
   input  wire logic [COORD_W-1:0]  path_y,
   input  wire logic                first_point,
   input  wire logic                last_point,
   output logic [MID_W-1:0]         item_data
);
   import nps_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int DIF_W = COORD_W + 1;

   logic                    active_ff, active_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        count_eff;
   nps_flags_type           flags;
   logic signed [DIF_W-1:0] diff_x, diff_y;
   logic [DIF_W-1:0]        mag_x, mag_y;

   // Classify: a new search opens on a marked first point or when none is open
   assign flags.start   = first_point || !active_ff;
   assign flags.last    = last_point;
   assign count_eff     = flags.start ? '0 : count_ff;
   assign flags.compare = (count_eff < CNT_W'(MAX_POINTS));

   assign diff_x = signed'({query_x[COORD_W-1], query_x}) - signed'({path_x[COORD_W-1], path_x});
   assign diff_y = signed'({query_y[COORD_W-1], query_y}) - signed'({path_y[COORD_W-1], path_y});
   assign mag_x  = diff_x[DIF_W-1] ? DIF_W'(-diff_x) : DIF_W'(diff_x);
   assign mag_y  = diff_y[DIF_W-1] ? DIF_W'(-diff_y) : DIF_W'(diff_y);

   assign item_data = {flags, mag_x, mag_y, path_x, path_y, count_eff[IDX_W-1:0]};

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      if (accept) begin
         active_in = !last_point;
         if (last_point) begin
            count_in = '0;
         end else if (flags.compare) begin
            count_in = count_eff + 1'b1;
         end else begin
            count_in = count_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/nps_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nps_back #(
   parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEFAULT,
   parameter int COORD_W    = nps_pkg::COORD_W_DEFAULT,
   parameter int MID_W      = nps_pkg::FLAGS_W + 4 * COORD_W + 2 + $clog2(MAX_POINTS),
   parameter int RES_W      = 2 * COORD_W + nps_pkg::INDEX_W + 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_en,
   input  wire logic [nps_pkg::RADIUS_W-1:0] csr_write_data,
   input  wire logic [MID_W-1:0]             mid_data,
   input  wire logic                         mid_empty,
   output logic                              mid_pop,
   output logic [RES_W-1:0]                  res_data,
   output logic                              res_push,
   input  wire logic                         res_full
);
   import nps_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int DIF_W = COORD_W + 1;
   localparam int SQ_W  = 2 * DIF_W;
   localparam int SUM_W = SQ_W + 1;
   localparam int CMP_W = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;

   nps_flags_type        mid_flags;
   logic [DIF_W-1:0]     mid_mag_x, mid_mag_y;
   logic [COORD_W-1:0]   mid_px, mid_py;
   logic [IDX_W-1:0]     mid_idx;

   logic [RADIUS_W-1:0]  radius_ff, radius_in;

   logic                 s1_valid_ff, s1_valid_in;
   nps_flags_type        s1_flags_ff;
   logic [SQ_W-1:0]      s1_sq_x_ff, s1_sq_y_ff;
   logic [COORD_W-1:0]   s1_px_ff, s1_py_ff;
   logic [IDX_W-1:0]     s1_idx_ff;

   logic [RADIUS_W-1:0]  best_dist_ff, best_dist_in;
   logic [COORD_W-1:0]   best_x_ff, best_x_in;
   logic [COORD_W-1:0]   best_y_ff, best_y_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                 best_found_ff, best_found_in;

   logic                 s1_go, take;
   logic [CMP_W-1:0]     dist_sq;
   logic [RADIUS_W-1:0]  base_dist;
   logic [COORD_W-1:0]   base_x, base_y;
   logic [IDX_W-1:0]     base_idx;
   logic                 base_found;
   logic                 hit;
   logic [IDX_W+INDEX_W-1:0] idx_wide;

   assign {mid_flags, mid_mag_x, mid_mag_y, mid_px, mid_py, mid_idx} = mid_data;

   // Hold stage one while a result waits on a full output queue
   assign s1_go   = s1_valid_ff && !(s1_flags_ff.last && res_full);
   assign take    = !mid_empty && (!s1_valid_ff || s1_go);
   assign mid_pop = take;

   assign radius_in   = csr_write_en ? csr_write_data : radius_ff;
   assign s1_valid_in = take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   // Stage two: sum, compare against the running best and update
   assign dist_sq    = CMP_W'(SUM_W'(s1_sq_x_ff) + SUM_W'(s1_sq_y_ff));
   assign base_dist  = s1_flags_ff.start ? radius_ff : best_dist_ff;
   assign base_x     = s1_flags_ff.start ? s1_px_ff : best_x_ff;
   assign base_y     = s1_flags_ff.start ? s1_py_ff : best_y_ff;
   assign base_idx   = s1_flags_ff.start ? '0 : best_idx_ff;
   assign base_found = s1_flags_ff.start ? 1'b0 : best_found_ff;
   assign hit        = s1_flags_ff.compare && (dist_sq < CMP_W'(base_dist));

   always_comb begin
      best_dist_in  = best_dist_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_idx_in   = best_idx_ff;
      best_found_in = best_found_ff;
      if (s1_go) begin
         best_dist_in  = hit ? dist_sq[RADIUS_W-1:0] : base_dist;
         best_x_in     = hit ? s1_px_ff : base_x;
         best_y_in     = hit ? s1_py_ff : base_y;
         best_idx_in   = hit ? s1_idx_ff : base_idx;
         best_found_in = hit || base_found;
      end
   end

   assign idx_wide = {{INDEX_W{1'b0}}, best_idx_in};
   assign res_push = s1_go && s1_flags_ff.last;
   assign res_data = {best_x_in, best_y_in, idx_wide[INDEX_W-1:0], best_found_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_RESET;
         s1_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         radius_ff     <= radius_in;
         s1_valid_ff   <= s1_valid_in;
         best_found_ff <= best_found_in;
      end
   end

   // Stage one: square both magnitudes
   always_ff @(posedge clock) begin
      if (take) begin
         s1_flags_ff <= mid_flags;
         s1_sq_x_ff  <= mid_mag_x * mid_mag_x;
         s1_sq_y_ff  <= mid_mag_y * mid_mag_y;
         s1_px_ff    <= mid_px;
         s1_py_ff    <= mid_py;
         s1_idx_ff   <= mid_idx;
      end
      best_dist_ff <= best_dist_in;
      best_x_ff    <= best_x_in;
      best_y_ff    <= best_y_in;
      best_idx_ff  <= best_idx_in;
   end

   `NPS_ASSERT_IMPLY(a_push_needs_last, clock, reset, res_push,
      s1_valid_ff && s1_flags_ff.last, "result pushed without a last point in stage one")
   `NPS_ASSERT_NEXT(a_stall_holds, clock, reset,
      s1_valid_ff && s1_flags_ff.last && res_full,
      s1_valid_ff && $stable(s1_idx_ff) && $stable(s1_px_ff), "stalled result lost")
   `NPS_ASSERT_IMPLY(a_start_compared, clock, reset, s1_valid_ff && s1_flags_ff.start,
      s1_flags_ff.compare && (s1_idx_ff == '0), "search start not taken as index zero")

endmodule
`default_nettype wire

FILE: src/nearest_path_point_search_core.sv
// Nearest path point search: running squared-distance minimum over a point stream.
// Throughput: one path point per cycle while neither queue is full, through a
// front stage, a two-entry queue, a square stage and a compare/update stage.
// A last point passes the middle queue and stage one before rsp_empty falls.
// Reset: synchronous, active high; clears queues and search state, radius to 1000 m.
`timescale 1ns / 1ps
`default_nettype none
module nearest_path_point_search_core #(
   parameter int MAX_POINTS  = nps_pkg::MAX_POINTS_DEFAULT,
   parameter int COORD_WIDTH = nps_pkg::COORD_W_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_write_en,
   input  wire logic [nps_pkg::RADIUS_W-1:0]    csr_write_data,
   // path points in
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic signed [COORD_WIDTH-1:0]   req_query_x,
   input  wire logic signed [COORD_WIDTH-1:0]   req_query_y,
   input  wire logic signed [COORD_WIDTH-1:0]   req_path_x,
   input  wire logic signed [COORD_WIDTH-1:0]   req_path_y,
   input  wire logic                            req_first_point,
   input  wire logic                            req_last_point,
   // nearest point out
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic signed [COORD_WIDTH-1:0]        rsp_nearest_x,
   output logic signed [COORD_WIDTH-1:0]        rsp_nearest_y,
   output logic [nps_pkg::INDEX_W-1:0]          rsp_nearest_index,
   output logic                                 rsp_found_within
);
   import nps_pkg::*;

   // Queue word between front and back: flags, two magnitudes, point, index
   localparam int MID_W = FLAGS_W + 4 * COORD_WIDTH + 2 + $clog2(MAX_POINTS);
   // Result word: nearest x, nearest y, index, found flag
   localparam int RES_W = 2 * COORD_WIDTH + INDEX_W + 1;

   logic             req_accept;
   logic [MID_W-1:0] front_data;
   logic [MID_W-1:0] mid_data;
   logic             mid_empty;
   logic             mid_pop;
   logic [RES_W-1:0] res_data;
   logic             res_push;
   logic             res_full;
   logic [RES_W-1:0] rsp_data;

   // A transfer in takes place when req_push is high and the middle queue has room
   assign req_accept = req_push && !req_full;

   // Front: track the open search and point count, classify, take differences
   nps_front #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_W    (COORD_WIDTH),
      .MID_W      (MID_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .query_x     (req_query_x),
      .query_y     (req_query_y),
      .path_x      (req_path_x),
      .path_y      (req_path_y),
      .first_point (req_first_point),
      .last_point  (req_last_point),
      .item_data   (front_data)
   );

   // Decouple the front from the back so each side can stall alone
   nps_queue #(
      .WIDTH (MID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_data),
      .full      (req_full),
      .pop       (mid_pop),
      .head_data (mid_data),
      .empty     (mid_empty)
   );

   // Back: square, compare against the running best, emit on the last point
   nps_back #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_W    (COORD_WIDTH),
      .MID_W      (MID_W),
      .RES_W      (RES_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mid_data       (mid_data),
      .mid_empty      (mid_empty),
      .mid_pop        (mid_pop),
      .res_data       (res_data),
      .res_push       (res_push),
      .res_full       (res_full)
   );

   // Hold finished results until the consumer transfers them
   nps_queue #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .head_data (rsp_data),
      .empty     (rsp_empty)
   );

   assign {rsp_nearest_x, rsp_nearest_y, rsp_nearest_index, rsp_found_within} = rsp_data;

endmodule
`default_nettype wire
